FILE: design/mu8_pkg.sv
// Package with the types and constants shared by the modified UTF-8 encoder.
package mu8_pkg;

    localparam int MaxBytes = 6;

    localparam logic [7:0] NulLead      = 8'hC0;
    localparam logic [7:0] ContBase     = 8'h80;
    localparam logic [7:0] SurrLead     = 8'hED;
    localparam logic [3:0] SurrHighTag  = 4'hA;
    localparam logic [3:0] SurrLowTag   = 4'hB;
    localparam logic [1:0] ContTag      = 2'b10;
    localparam logic [2:0] Lead2Tag     = 3'b110;
    localparam logic [3:0] Lead3Tag     = 4'b1110;
    localparam logic [4:0] Lead4Tag     = 5'b11110;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       has_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [2:0]               nbytes;
        logic                     summ;
        logic [15:0]              len;
        logic                     inv;
    } t_burst;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_length;
        logic [15:0] encoded_length;
        logic        input_invalid;
        logic        final_item;
    } t_out_item;

endpackage

FILE: design/mu8_if.sv
// Handshake interfaces for the input and result channels of the encoder.
interface mu8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       has_byte;
    logic       end_of_string;

    modport source(output valid, output in_byte, output has_byte, output end_of_string,
                   input ready);
    modport sink(input valid, input in_byte, input has_byte, input end_of_string,
                 output ready);
endinterface

interface mu8_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_length;
    logic [15:0] encoded_length;
    logic        input_invalid;
    logic        final_item;

    modport source(output valid, output out_byte, output is_length, output encoded_length,
                   output input_invalid, output final_item, input ready);
    modport sink(input valid, input out_byte, input is_length, input encoded_length,
                 input input_invalid, input final_item, output ready);
endinterface

FILE: design/mu8_in_reg.sv
// Input register that holds one accepted beat until the encoder core takes it.
module mu8_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mu8_pkg::t_in_item i_item,
    input  logic              i_step,
    output logic              o_valid,
    output mu8_pkg::t_in_item o_item
);

    logic              r_valid;
    mu8_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_step;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_step) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: design/mu8_core.sv
// Encoder core: per-string state and the burst of results for one input beat.
module mu8_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  mu8_pkg::t_in_item i_item,
    output logic              o_load,
    output mu8_pkg::t_burst   o_burst
);

    logic [1:0]      r_copy, n_copy;
    logic            r_four, n_four;
    logic [2:0][7:0] r_held, n_held;
    logic [1:0]      r_hcnt, n_hcnt;
    logic [1:0]      r_chk, n_chk;
    logic [15:0]     r_mcnt, n_mcnt;
    logic [15:0]     r_rcnt, n_rcnt;
    logic            r_inv, n_inv;

    logic [7:0]      b;
    logic [3:0]      high_sel;
    logic            end_inv;
    mu8_pkg::t_burst burst;

    assign b        = i_item.in_byte;
    assign high_sel = {r_held[0][1:0], r_held[1][5:4]} - 4'd1;

    always_comb begin
        n_copy  = r_copy;
        n_four  = r_four;
        n_held  = r_held;
        n_hcnt  = r_hcnt;
        n_chk   = r_chk;
        n_mcnt  = r_mcnt;
        n_rcnt  = r_rcnt;
        n_inv   = r_inv;
        end_inv = 1'b0;
        burst   = '0;

        if (i_item.has_byte) begin
            n_rcnt = r_rcnt + 16'd1;
            if ((r_four || (r_copy != 2'd0)) && (r_chk != 2'd0)) begin
                if (b[7:6] != mu8_pkg::ContTag) begin
                    n_inv = 1'b1;
                end
                n_chk = r_chk - 2'd1;
            end
            priority if (r_four) begin
                if (r_hcnt != 2'd3) begin
                    n_held[r_hcnt] = b;
                    n_hcnt         = r_hcnt + 2'd1;
                end else begin
                    burst.bytes[0] = mu8_pkg::SurrLead;
                    burst.bytes[1] = {mu8_pkg::SurrHighTag, high_sel};
                    burst.bytes[2] = {mu8_pkg::ContTag, r_held[1][3:0], r_held[2][5:4]};
                    burst.bytes[3] = mu8_pkg::SurrLead;
                    burst.bytes[4] = {mu8_pkg::SurrLowTag, r_held[2][3:0]};
                    burst.bytes[5] = b;
                    burst.nbytes   = 3'd6;
                    n_four         = 1'b0;
                    n_hcnt         = 2'd0;
                    n_chk          = 2'd0;
                end
            end else if (r_copy != 2'd0) begin
                burst.bytes[0] = b;
                burst.nbytes   = 3'd1;
                n_copy         = r_copy - 2'd1;
            end else if (!b[7]) begin
                if (b == 8'd0) begin
                    burst.bytes[0] = mu8_pkg::NulLead;
                    burst.bytes[1] = mu8_pkg::ContBase;
                    burst.nbytes   = 3'd2;
                    n_mcnt         = r_mcnt + 16'd2;
                end else begin
                    burst.bytes[0] = b;
                    burst.nbytes   = 3'd1;
                    n_mcnt         = r_mcnt + 16'd1;
                end
            end else if (b[7:5] == mu8_pkg::Lead2Tag) begin
                burst.bytes[0] = b;
                burst.nbytes   = 3'd1;
                n_copy         = 2'd1;
                n_chk          = 2'd1;
                n_mcnt         = r_mcnt + 16'd2;
            end else if (b[7:4] == mu8_pkg::Lead3Tag) begin
                burst.bytes[0] = b;
                burst.nbytes   = 3'd1;
                n_copy         = 2'd2;
                n_chk          = 2'd2;
                n_mcnt         = r_mcnt + 16'd3;
            end else if (b[7:3] == mu8_pkg::Lead4Tag) begin
                n_four    = 1'b1;
                n_held[0] = b;
                n_hcnt    = 2'd1;
                n_chk     = 2'd3;
                n_mcnt    = r_mcnt + 16'd6;
            end else begin
                n_inv = 1'b1;
            end
        end

        if (i_item.end_of_string) begin
            end_inv     = n_inv || (n_copy != 2'd0) || n_four;
            burst.summ  = 1'b1;
            burst.inv   = end_inv;
            burst.len   = end_inv ? n_rcnt : n_mcnt;
            n_copy      = 2'd0;
            n_four      = 1'b0;
            n_hcnt      = 2'd0;
            n_chk       = 2'd0;
            n_mcnt      = 16'd0;
            n_rcnt      = 16'd0;
            n_inv       = 1'b0;
        end
    end

    assign o_burst = burst;
    assign o_load  = i_step && ((burst.nbytes != 3'd0) || burst.summ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_copy <= 2'd0;
            r_four <= 1'b0;
            r_hcnt <= 2'd0;
            r_chk  <= 2'd0;
            r_mcnt <= 16'd0;
            r_rcnt <= 16'd0;
            r_inv  <= 1'b0;
        end else if (i_step) begin
            r_copy <= n_copy;
            r_four <= n_four;
            r_hcnt <= n_hcnt;
            r_chk  <= n_chk;
            r_mcnt <= n_mcnt;
            r_rcnt <= n_rcnt;
            r_inv  <= n_inv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_held <= n_held;
        end
    end

endmodule

FILE: design/mu8_out_buf.sv
// Result register that holds one burst and hands it out one beat at a time.
module mu8_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  mu8_pkg::t_burst     i_burst,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output mu8_pkg::t_out_item  o_item
);

    logic            r_valid;
    mu8_pkg::t_burst r_burst;
    logic [2:0]      r_idx;
    logic            at_summ;
    logic            last;
    logic            take;

    assign at_summ = (r_idx == r_burst.nbytes);
    assign last    = r_burst.summ ? at_summ : (r_idx == r_burst.nbytes - 3'd1);
    assign take    = r_valid && i_ready;
    assign o_free  = !r_valid || (take && last);
    assign o_valid = r_valid;

    always_comb begin
        o_item = '0;
        if (at_summ) begin
            o_item.is_length      = 1'b1;
            o_item.encoded_length = r_burst.len;
            o_item.input_invalid  = r_burst.inv;
            o_item.final_item     = 1'b1;
        end else begin
            o_item.out_byte = r_burst.bytes[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (i_load && o_free) begin
            r_valid <= 1'b1;
            r_idx   <= 3'd0;
        end else if (take && last) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_burst <= i_burst;
        end
    end

endmodule

FILE: design/modified_utf8_encoder.sv
// Top level of the modified UTF-8 encoder.
// Each input beat carries one UTF-8 byte and/or an end-of-string mark, and the block returns
// the modified UTF-8 bytes followed, at the end of each string, by one summary beat that
// holds the 16-bit encoded length and an invalid-input flag. An input beat is registered in an
// input register and then processed by the encoder core, and its results are held in a result
// register that sends one beat per cycle on the output port while the output is ready. A new
// input beat is taken every cycle as long as each beat yields at most one result and the
// output is not stalled; a beat that yields more results holds the result register until all
// are sent (two for NUL, six for the last byte of a four-byte sequence, plus one for the
// summary), and the lead and first two following bytes of a four-byte sequence give no
// result. The single output port sets the rate.
module modified_utf8_encoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mu8_in_if.sink           i_in,
    mu8_out_if.source        o_out
);

    mu8_pkg::t_in_item  in_item;
    mu8_pkg::t_in_item  core_item;
    mu8_pkg::t_burst    burst;
    mu8_pkg::t_out_item out_item;
    logic               core_valid;
    logic               step;
    logic               load;
    logic               free;

    assign in_item.in_byte       = i_in.in_byte;
    assign in_item.has_byte      = i_in.has_byte;
    assign in_item.end_of_string = i_in.end_of_string;

    assign step = core_valid && free;

    mu8_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (in_item),
        .i_step  (step),
        .o_valid (core_valid),
        .o_item  (core_item)
    );

    mu8_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (core_item),
        .o_load  (load),
        .o_burst (burst)
    );

    mu8_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_burst (burst),
        .o_free  (free),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (out_item)
    );

    assign o_out.out_byte       = out_item.out_byte;
    assign o_out.is_length      = out_item.is_length;
    assign o_out.encoded_length = out_item.encoded_length;
    assign o_out.input_invalid  = out_item.input_invalid;
    assign o_out.final_item     = out_item.final_item;

endmodule

FILE: design/mu8_checker.sv
// Port-level checks on the encoder's result channel, bound to the top level.
module mu8_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [7:0]  i_out_byte,
    input logic        i_is_length,
    input logic [15:0] i_encoded_length,
    input logic        i_input_invalid,
    input logic        i_final_item
);

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_out_byte) && $stable(i_is_length)
            && $stable(i_encoded_length) && $stable(i_input_invalid) && $stable(i_final_item))
        else $error("result beat changed while stalled");

    // Only the summary beat closes a string.
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_final_item == i_is_length))
        else $error("final mark and summary mark disagree");

    // Byte beats carry no length and no invalid flag.
    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_is_length |-> (i_encoded_length == 16'd0) && !i_input_invalid)
        else $error("byte beat carries summary fields");

    // Summary beats carry a zero byte.
    a_summ_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_is_length |-> (i_out_byte == 8'd0))
        else $error("summary beat carries a byte");

    // Nothing is offered in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result offered right after reset");

endmodule

bind modified_utf8_encoder mu8_checker u_mu8_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_out.valid),
    .i_ready          (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_is_length      (o_out.is_length),
    .i_encoded_length (o_out.encoded_length),
    .i_input_invalid  (o_out.input_invalid),
    .i_final_item     (o_out.final_item)
);
